[rtl/swot_pkg.sv]
package swot_pkg;

    localparam int ANGLE_BITS_DEF = 16;

    localparam int WHEELS   = 4;
    localparam int LANE_ST  = 6;
    localparam int MERGE_ST = 3;
    localparam int STAGES   = LANE_ST + MERGE_ST;

    localparam int VW = 26;
    localparam int SW = VW + 2;

    localparam logic [1:0] REG_WHEEL_RADIUS   = 2'd0;
    localparam logic [1:0] REG_INV_HALF_BASE  = 2'd1;
    localparam logic [1:0] REG_INV_HALF_TRACK = 2'd2;

    localparam logic [15:0] RADIUS_RST = 16'd13107;
    localparam logic [15:0] INV_B_RST  = 16'd640;
    localparam logic [15:0] INV_T_RST  = 16'd640;

    localparam logic [15:0] SIN_A = 16'd51472;
    localparam logic [14:0] SIN_B = 15'd21024;
    localparam logic [11:0] SIN_C = 12'd2320;

    localparam logic [31:0] QUARTER = 32'h4000_0000;
    localparam logic [31:0] HALF    = 32'h8000_0000;

    typedef struct packed {
        logic signed [15:0] spin_a;
        logic signed [15:0] spin_b;
        logic signed [15:0] spin_c;
        logic signed [15:0] spin_d;
        logic [15:0]        steer_a;
        logic [15:0]        steer_b;
        logic [15:0]        steer_c;
        logic [15:0]        steer_d;
    } in_t;

    typedef struct packed {
        logic signed [15:0] forward_speed;
        logic signed [15:0] lateral_speed;
        logic signed [15:0] yaw_rate;
    } out_t;

    // {negate, folded magnitude >> 15}
    function automatic logic [16:0] sine_fold(input logic [31:0] x);
        logic [31:0] xf;
        logic [31:0] m;
        logic        neg;
        xf  = ((x + QUARTER) & HALF) != 32'd0 ? HALF - x : x;
        neg = xf[31];
        m   = neg ? 32'd0 - xf : xf;
        return {neg, m[30:15]};
    endfunction

endpackage

[rtl/swot_lane.sv]
module swot_lane #(
    parameter int ANGLE_BITS = swot_pkg::ANGLE_BITS_DEF
) (
    input  logic                            clk,
    input  logic [swot_pkg::LANE_ST-1:0]    en,
    input  logic [15:0]                     wheel_radius,
    input  logic signed [15:0]              spin,
    input  logic [15:0]                     steer,
    output logic signed [swot_pkg::VW-1:0]  vx,
    output logic signed [swot_pkg::VW-1:0]  vy
);

    logic [ANGLE_BITS-1:0] ang;
    logic [31:0]           a_sin;
    logic [16:0]           f_sin;
    logic [16:0]           f_cos;

    assign ang   = ANGLE_BITS'(steer);
    assign a_sin = {ang, {(32 - ANGLE_BITS){1'b0}}};
    assign f_sin = swot_pkg::sine_fold(a_sin);
    assign f_cos = swot_pkg::sine_fold(a_sin + swot_pkg::QUARTER);

    // index 0: sine (vy), index 1: cosine (vx)
    logic [15:0]        z1_reg [2];
    logic               n1_reg [2];
    logic signed [32:0] rw1_reg;
    logic [15:0]        z2_reg [2];
    logic [15:0]        q2_reg [2];
    logic               n2_reg [2];
    logic signed [32:0] rw2_reg;
    logic [15:0]        z3_reg [2];
    logic [15:0]        q3_reg [2];
    logic [12:0]        t3_reg [2];
    logic               n3_reg [2];
    logic signed [32:0] rw3_reg;
    logic [15:0]        z4_reg [2];
    logic [15:0]        t4_reg [2];
    logic               n4_reg [2];
    logic signed [32:0] rw4_reg;
    logic signed [17:0] tr5_reg [2];
    logic signed [32:0] rw5_reg;
    logic signed [swot_pkg::VW-1:0] v6_reg [2];

    logic [31:0] p2 [2];
    logic [27:0] p3 [2];
    logic [30:0] p4 [2];
    logic [31:0] p5 [2];
    logic [16:0] t5 [2];
    logic signed [50:0] p6 [2];
    logic signed [50:0] r6 [2];

    always_comb
    begin
        for (int k = 0; k < 2; k++)
        begin
            p2[k] = 32'(z1_reg[k]) * 32'(z1_reg[k]);
            p3[k] = 28'(q2_reg[k]) * 28'(swot_pkg::SIN_C);
            p4[k] = 31'(q3_reg[k]) * 31'(swot_pkg::SIN_B - 15'(t3_reg[k]));
            p5[k] = 32'(z4_reg[k]) * 32'(swot_pkg::SIN_A - t4_reg[k]);
            t5[k] = p5[k][31:15];
            p6[k] = 51'(rw5_reg) * 51'(tr5_reg[k]);
            r6[k] = p6[k] + (51'sd1 <<< 22);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            z1_reg[0] <= f_sin[15:0];
            n1_reg[0] <= f_sin[16];
            z1_reg[1] <= f_cos[15:0];
            n1_reg[1] <= f_cos[16];
            rw1_reg   <= $signed({1'b0, wheel_radius}) * spin;
        end
        if (en[1])
        begin
            for (int k = 0; k < 2; k++)
            begin
                z2_reg[k] <= z1_reg[k];
                q2_reg[k] <= p2[k][30:15];
                n2_reg[k] <= n1_reg[k];
            end
            rw2_reg <= rw1_reg;
        end
        if (en[2])
        begin
            for (int k = 0; k < 2; k++)
            begin
                z3_reg[k] <= z2_reg[k];
                q3_reg[k] <= q2_reg[k];
                t3_reg[k] <= p3[k][27:15];
                n3_reg[k] <= n2_reg[k];
            end
            rw3_reg <= rw2_reg;
        end
        if (en[3])
        begin
            for (int k = 0; k < 2; k++)
            begin
                z4_reg[k] <= z3_reg[k];
                t4_reg[k] <= p4[k][30:15];
                n4_reg[k] <= n3_reg[k];
            end
            rw4_reg <= rw3_reg;
        end
        if (en[4])
        begin
            for (int k = 0; k < 2; k++)
            begin
                tr5_reg[k] <= n4_reg[k] ? -$signed({1'b0, t5[k]}) : $signed({1'b0, t5[k]});
            end
            rw5_reg <= rw4_reg;
        end
        if (en[5])
        begin
            for (int k = 0; k < 2; k++)
            begin
                v6_reg[k] <= r6[k][swot_pkg::VW+22:23];
            end
        end
    end

    assign vy = v6_reg[0];
    assign vx = v6_reg[1];

endmodule

[rtl/swot_merge.sv]
module swot_merge (
    input  logic                                clk,
    input  logic [swot_pkg::MERGE_ST-1:0]       en,
    input  logic [15:0]                         inv_half_base,
    input  logic [15:0]                         inv_half_track,
    input  logic signed [swot_pkg::VW-1:0]      vx [swot_pkg::WHEELS],
    input  logic signed [swot_pkg::VW-1:0]      vy [swot_pkg::WHEELS],
    output swot_pkg::out_t                      result
);

    localparam int SW = swot_pkg::SW;

    logic signed [SW-1:0] sx_reg;
    logic signed [SW-1:0] sy_reg;
    logic signed [SW-1:0] cx_reg;
    logic signed [SW-1:0] cy_reg;
    logic signed [18:0]   mx_reg;
    logic signed [18:0]   my_reg;
    logic signed [SW+16:0] px_reg;
    logic signed [SW+16:0] py_reg;
    swot_pkg::out_t        out_reg;

    logic signed [SW-1:0]  e [swot_pkg::WHEELS][2];
    logic signed [SW-1:0]  rx;
    logic signed [SW-1:0]  ry;
    logic signed [SW+17:0] ysum;
    logic signed [SW+17:0] yrnd;
    logic signed [26:0]    yaw;
    logic signed [18:0]    lat;

    function automatic logic signed [15:0] sat16(input logic signed [26:0] v);
        if (v > 27'sd32767)
            return 16'sh7FFF;
        else if (v < -27'sd32768)
            return 16'sh8000;
        else
            return v[15:0];
    endfunction

    always_comb
    begin
        for (int i = 0; i < swot_pkg::WHEELS; i++)
        begin
            e[i][0] = SW'(vx[i]);
            e[i][1] = SW'(vy[i]);
        end
        rx   = sx_reg + (SW'(1) <<< 9);
        ry   = sy_reg + (SW'(1) <<< 9);
        ysum = (SW+18)'(px_reg) + (SW+18)'(py_reg);
        yrnd = ysum + ((SW+18)'(1) <<< 18);
        yaw  = yrnd[SW+17:19];
        lat  = -mx_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            sx_reg <= e[0][0] + e[1][0] + e[2][0] + e[3][0];
            sy_reg <= e[0][1] + e[1][1] + e[2][1] + e[3][1];
            cx_reg <= e[1][0] + e[2][0] - e[0][0] - e[3][0];
            cy_reg <= e[0][1] + e[1][1] - e[2][1] - e[3][1];
        end
        if (en[1])
        begin
            mx_reg <= 19'(rx >>> 10);
            my_reg <= 19'(ry >>> 10);
            px_reg <= $signed({1'b0, inv_half_track}) * cx_reg;
            py_reg <= $signed({1'b0, inv_half_base}) * cy_reg;
        end
        if (en[2])
        begin
            out_reg.forward_speed <= sat16(27'(my_reg));
            out_reg.lateral_speed <= sat16(27'(lat));
            out_reg.yaw_rate      <= sat16(yaw);
        end
    end

    assign result = out_reg;

endmodule

[rtl/swerve_odometry_twist_core.sv]
// Swerve odometry twist: four steered wheels in, body forward speed, lateral
// speed and yaw rate out (Q8.8, saturated). Fully pipelined with four wheel
// lanes and a merge stage: one transaction per cycle unless out_ready stalls
// the pipeline. Nine register stages, the first loaded at the accepting edge:
// six lane stages for sine/cosine polynomial and wheel products, three merge
// stages. Registers: 0 wheel_radius, 1 inv_half_base,
// 2 inv_half_track; write only while idle, other indexes are ignored.
module swerve_odometry_twist_core #(
    parameter int ANGLE_BITS = swot_pkg::ANGLE_BITS_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  swot_pkg::in_t   in_data,
    output logic            out_valid,
    input  logic            out_ready,
    output swot_pkg::out_t  out_data,
    input  logic            cfg_valid,
    output logic            cfg_ready,
    input  logic [1:0]      cfg_index,
    input  logic [15:0]     cfg_data
);

    localparam int NS = swot_pkg::STAGES;
    localparam int LS = swot_pkg::LANE_ST;

    logic [15:0]   radius_reg;
    logic [15:0]   inv_b_reg;
    logic [15:0]   inv_t_reg;
    logic [NS-1:0] vld_reg;
    logic [NS-1:0] vld_next;
    logic [NS-1:0] en;

    logic signed [15:0]             spin  [swot_pkg::WHEELS];
    logic [15:0]                    steer [swot_pkg::WHEELS];
    logic signed [swot_pkg::VW-1:0] vx    [swot_pkg::WHEELS];
    logic signed [swot_pkg::VW-1:0] vy    [swot_pkg::WHEELS];

    assign spin[0]  = in_data.spin_a;
    assign spin[1]  = in_data.spin_b;
    assign spin[2]  = in_data.spin_c;
    assign spin[3]  = in_data.spin_d;
    assign steer[0] = in_data.steer_a;
    assign steer[1] = in_data.steer_b;
    assign steer[2] = in_data.steer_c;
    assign steer[3] = in_data.steer_d;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        en[NS-1] = !vld_reg[NS-1] || out_ready;
        for (int k = NS - 2; k >= 0; k--)
        begin
            en[k] = !vld_reg[k] || en[k+1];
        end
        vld_next = vld_reg;
        if (en[0])
            vld_next[0] = in_valid;
        for (int k = 1; k < NS; k++)
        begin
            if (en[k])
                vld_next[k] = vld_reg[k-1];
        end
    end

    assign in_ready  = en[0];
    assign out_valid = vld_reg[NS-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg    <= '0;
            radius_reg <= swot_pkg::RADIUS_RST;
            inv_b_reg  <= swot_pkg::INV_B_RST;
            inv_t_reg  <= swot_pkg::INV_T_RST;
        end
        else
        begin
            vld_reg <= vld_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    swot_pkg::REG_WHEEL_RADIUS:   radius_reg <= cfg_data;
                    swot_pkg::REG_INV_HALF_BASE:  inv_b_reg  <= cfg_data;
                    swot_pkg::REG_INV_HALF_TRACK: inv_t_reg  <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

    for (genvar i = 0; i < swot_pkg::WHEELS; i++)
    begin : g_lane
        swot_lane #(
            .ANGLE_BITS(ANGLE_BITS)
        ) u_lane (
            .clk         (clk),
            .en          (en[LS-1:0]),
            .wheel_radius(radius_reg),
            .spin        (spin[i]),
            .steer       (steer[i]),
            .vx          (vx[i]),
            .vy          (vy[i])
        );
    end

    swot_merge u_merge (
        .clk           (clk),
        .en            (en[NS-1:LS]),
        .inv_half_base (inv_b_reg),
        .inv_half_track(inv_t_reg),
        .vx            (vx),
        .vy            (vy),
        .result        (out_data)
    );

    a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (&vld_reg) && !out_ready)
        else $error("input stalled with a bubble in the pipeline");

    a_out_drop: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(out_valid) |-> $past(out_ready))
        else $error("result dropped without a transaction");

    a_cfg_radius: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid && cfg_index == swot_pkg::REG_WHEEL_RADIUS |=> radius_reg == $past(cfg_data))
        else $error("wheel radius write lost");

    a_advance: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> vld_reg[0])
        else $error("accepted transaction not captured");

endmodule

[sim/tb.sv]
`timescale 1ns / 100ps

module tb;

    localparam int ANGLE_W = swot_pkg::ANGLE_BITS_DEF;
    localparam int LATENCY = 12;
    localparam int WDOG_LIMIT = 5000;
    localparam logic [1:0] REG_NONE = 2'd3;

    logic           clk = 1'b0;
    logic           rst_n = 1'b0;
    logic           in_valid = 1'b0;
    logic           in_ready;
    swot_pkg::in_t  in_data = '0;
    logic           out_valid;
    logic           out_ready = 1'b0;
    swot_pkg::out_t out_data;
    logic           cfg_valid = 1'b0;
    logic           cfg_ready;
    logic [1:0]     cfg_index = '0;
    logic [15:0]    cfg_data = '0;

    logic [15:0] radius_q = swot_pkg::RADIUS_RST;
    logic [15:0] inv_b_q = swot_pkg::INV_B_RST;
    logic [15:0] inv_t_q = swot_pkg::INV_T_RST;

    swot_pkg::in_t  pending_q[$];
    swot_pkg::out_t twist_q[$];
    int   mismatches = 0;
    int   idle_cycles = 0;
    int   send_gap = 0;
    int   recv_stall = 0;
    int   results_seen = 0;
    bit   no_idle = 1'b0;

    swerve_odometry_twist_core u_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #5 clk = ~clk;

    function automatic longint rnd_shift(longint v, int s);
        return (v + (64'sd1 <<< (s - 1))) >>> s;
    endfunction

    function automatic logic signed [15:0] clamp16(longint v);
        if (v > 32767) return 16'sd32767;
        if (v < -32768) return -16'sd32768;
        return v[15:0];
    endfunction

    function automatic longint poly_sine(logic [31:0] x);
        logic [31:0] xf;
        logic [31:0] m;
        logic        neg;
        longint      z, z2, t;
        xf = (((x + 32'h4000_0000) & 32'h8000_0000) != 0) ? 32'h8000_0000 - x : x;
        neg = xf[31];
        m = neg ? 32'd0 - xf : xf;
        z = longint'(m >> 15);
        z2 = (z * z) >>> 15;
        t = (z2 * 2320) >>> 15;
        t = (z2 * (21024 - t)) >>> 15;
        t = (z * (51472 - t)) >>> 15;
        return neg ? -t : t;
    endfunction

    function automatic swot_pkg::out_t body_twist(swot_pkg::in_t it);
        logic signed [15:0] spin[4];
        logic [15:0]        steer[4];
        longint vx[4], vy[4];
        longint sx, sy, rw, c, s, tsum, dxs, dys;
        logic [31:0] ang;
        swot_pkg::out_t r;
        spin = '{it.spin_a, it.spin_b, it.spin_c, it.spin_d};
        steer = '{it.steer_a, it.steer_b, it.steer_c, it.steer_d};
        sx = 0;
        sy = 0;
        for (int i = 0; i < 4; i++)
        begin
            rw = longint'(radius_q) * longint'(spin[i]);
            ang = (32'(steer[i]) & ((32'd1 << ANGLE_W) - 1)) << (32 - ANGLE_W);
            c = poly_sine(ang + 32'h4000_0000);
            s = poly_sine(ang);
            vx[i] = rnd_shift(rw * c, 23);
            vy[i] = rnd_shift(rw * s, 23);
            sx += vx[i];
            sy += vy[i];
        end
        dxs = -(4 * vx[0] - sx) + (4 * vx[1] - sx) + (4 * vx[2] - sx) - (4 * vx[3] - sx);
        dys = (4 * vy[0] - sy) + (4 * vy[1] - sy) - (4 * vy[2] - sy) - (4 * vy[3] - sy);
        tsum = longint'(inv_t_q) * dxs + longint'(inv_b_q) * dys;
        r.forward_speed = clamp16(rnd_shift(sy, 10));
        r.lateral_speed = clamp16(-rnd_shift(sx, 10));
        r.yaw_rate = clamp16(rnd_shift(tsum, 21));
        return r;
    endfunction

    function automatic logic [15:0] rnd_angle();
        case ($urandom_range(0, 3))
            0: return 16'($urandom_range(0, 3)) << 14;
            1: return (16'($urandom_range(0, 3)) << 14) + 16'($urandom_range(0, 64)) - 16'd32;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic swot_pkg::in_t rnd_wheels();
        swot_pkg::in_t it;
        logic [15:0] base_spin;
        logic [15:0] base_ang;
        it = swot_pkg::in_t'({$urandom, $urandom, $urandom, $urandom});
        if ($urandom_range(0, 2) != 0)
        begin
            // wheels roughly agree, as on a moving robot
            base_spin = ($urandom_range(0, 7) == 0) ? 16'h7fff : 16'($urandom);
            base_ang = rnd_angle();
            it.spin_a = base_spin + 16'($urandom_range(0, 512)) - 16'd256;
            it.spin_b = base_spin + 16'($urandom_range(0, 512)) - 16'd256;
            it.spin_c = base_spin + 16'($urandom_range(0, 512)) - 16'd256;
            it.spin_d = base_spin + 16'($urandom_range(0, 512)) - 16'd256;
            it.steer_a = base_ang + 16'($urandom_range(0, 2048)) - 16'd1024;
            it.steer_b = base_ang + 16'($urandom_range(0, 2048)) - 16'd1024;
            it.steer_c = base_ang + 16'($urandom_range(0, 2048)) - 16'd1024;
            it.steer_d = base_ang + 16'($urandom_range(0, 2048)) - 16'd1024;
        end
        return it;
    endfunction

    function automatic swot_pkg::in_t uniform(logic [15:0] w, logic [15:0] a);
        return '{w, w, w, w, a, a, a, a};
    endfunction

    // driver
    always @(posedge clk)
    begin
        if (rst_n && ((in_valid && in_ready) || !in_valid))
        begin
            if (send_gap > 0)
            begin
                send_gap <= send_gap - 1;
                in_valid <= 1'b0;
            end
            else if (pending_q.size() > 0)
            begin
                in_data <= pending_q.pop_front();
                in_valid <= 1'b1;
                send_gap <= no_idle ? 0 : $urandom_range(0, 3);
            end
            else
                in_valid <= 1'b0;
        end
    end

    // monitor and predictor
    always @(posedge clk)
    begin
        swot_pkg::out_t want;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                results_seen++;
                if (twist_q.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result %h", out_data);
                end
                else
                begin
                    want = twist_q.pop_front();
                    if (want.forward_speed !== out_data.forward_speed ||
                        want.lateral_speed !== out_data.lateral_speed ||
                        want.yaw_rate !== out_data.yaw_rate)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch exp fwd %0d lat %0d yaw %0d got %0d %0d %0d",
                                     want.forward_speed, want.lateral_speed, want.yaw_rate,
                                     out_data.forward_speed, out_data.lateral_speed,
                                     out_data.yaw_rate);
                    end
                end
                if (results_seen == 300)
                    recv_stall = 300;
                else
                    recv_stall = no_idle ? 0 : $urandom_range(0, 3);
                out_ready <= (recv_stall == 0);
            end
            else if (recv_stall > 0)
            begin
                recv_stall--;
                out_ready <= (recv_stall == 0);
            end
            else
                out_ready <= 1'b1;
            if (in_valid && in_ready)
                twist_q.push_back(body_twist(in_data));
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WDOG_LIMIT)
        begin
            $display("swerve_odometry_twist_core regression: fail");
            $finish;
        end
    end

    task automatic drain();
        @(negedge clk);
        while (pending_q.size() > 0 || in_valid || twist_q.size() > 0)
            @(negedge clk);
        repeat (LATENCY) @(negedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [15:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
        while (!cfg_ready)
            @(negedge clk);
        @(posedge clk);
        cfg_valid <= 1'b0;
        case (idx)
            swot_pkg::REG_WHEEL_RADIUS: radius_q = val;
            swot_pkg::REG_INV_HALF_BASE: inv_b_q = val;
            swot_pkg::REG_INV_HALF_TRACK: inv_t_q = val;
            default: ;
        endcase
    endtask

    task automatic run_random(int n);
        for (int i = 0; i < n; i++)
        begin
            @(negedge clk);
            if (i % 60 == 0)
                no_idle = ($urandom_range(0, 3) == 0);
            pending_q.push_back(rnd_wheels());
        end
        drain();
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        pending_q.push_back('0);
        pending_q.push_back(uniform(16'h7fff, 16'h0000));
        pending_q.push_back(uniform(16'h8000, 16'h0000));
        pending_q.push_back(uniform(16'h7fff, 16'h4000));
        pending_q.push_back(uniform(16'h8000, 16'h4000));
        pending_q.push_back(uniform(16'h7fff, 16'h8000));
        pending_q.push_back(uniform(16'h7fff, 16'hc000));
        pending_q.push_back(uniform(16'h8000, 16'hffff));
        pending_q.push_back(uniform(16'h0100, 16'h2000));
        pending_q.push_back(uniform(16'hffff, 16'hffff));
        pending_q.push_back('{16'h7fff, 16'h8000, 16'h7fff, 16'h8000,
                              16'h0000, 16'h4000, 16'h8000, 16'hc000});
        pending_q.push_back('{16'h8000, 16'h7fff, 16'h8000, 16'h7fff,
                              16'h4000, 16'h4000, 16'hc000, 16'hc000});
        pending_q.push_back('{16'h0100, 16'h0100, 16'h0100, 16'h0100,
                              16'h6000, 16'h2000, 16'he000, 16'ha000});
        drain();
        run_random(200);

        write_reg(swot_pkg::REG_WHEEL_RADIUS, 16'hffff);
        write_reg(swot_pkg::REG_INV_HALF_BASE, 16'hffff);
        write_reg(swot_pkg::REG_INV_HALF_TRACK, 16'hffff);
        pending_q.push_back(uniform(16'h7fff, 16'h4000));
        pending_q.push_back(uniform(16'h8000, 16'h0000));
        pending_q.push_back(uniform(16'h7fff, 16'h0000));
        pending_q.push_back('{16'h7fff, 16'h8000, 16'h7fff, 16'h8000,
                              16'h4000, 16'h4000, 16'hc000, 16'hc000});
        pending_q.push_back('{16'h8000, 16'h7fff, 16'h7fff, 16'h8000,
                              16'h0000, 16'h0000, 16'h8000, 16'h8000});
        drain();
        run_random(200);

        write_reg(swot_pkg::REG_INV_HALF_BASE, 16'h0000);
        write_reg(swot_pkg::REG_INV_HALF_TRACK, 16'h0000);
        write_reg(REG_NONE, 16'h1234);
        run_random(150);

        write_reg(swot_pkg::REG_WHEEL_RADIUS, 16'h0000);
        write_reg(swot_pkg::REG_INV_HALF_BASE, 16'h0001);
        write_reg(swot_pkg::REG_INV_HALF_TRACK, 16'h0001);
        run_random(60);

        write_reg(swot_pkg::REG_WHEEL_RADIUS, 16'($urandom));
        write_reg(swot_pkg::REG_INV_HALF_BASE, 16'($urandom));
        write_reg(swot_pkg::REG_INV_HALF_TRACK, 16'($urandom));
        run_random(150);

        write_reg(swot_pkg::REG_WHEEL_RADIUS, swot_pkg::RADIUS_RST);
        write_reg(swot_pkg::REG_INV_HALF_BASE, 16'($urandom_range(1, 4096)));
        write_reg(swot_pkg::REG_INV_HALF_TRACK, 16'($urandom_range(1, 4096)));
        run_random(120);

        if (mismatches == 0 && twist_q.size() == 0)
            $display("swerve_odometry_twist_core regression: pass");
        else
            $display("swerve_odometry_twist_core regression: fail");
        $finish;
    end
endmodule
